[rtl/tde_pkg.sv]
// Shared types, constants and helper functions for the telemetry record delta encoder.
package tde_pkg;

  localparam int NumGroups = 5;
  localparam int SensorsPerRecord = 16;
  localparam int GroupIdxW = 3;
  localparam int SumW = 16;
  localparam int FlagWordW = 2 * NumGroups;

  typedef logic [2:0] flag_t;

  localparam flag_t FLAG_NODATA = 3'd2;
  localparam flag_t FLAG_SAT    = 3'd3;
  localparam flag_t FLAG_NONE   = 3'd7;

  localparam logic [1:0] TYPE_NODATA = 2'b10;
  localparam logic [1:0] TYPE_SAT    = 2'b11;

  localparam logic [6:0] LEN_CHUNK_W  = 7'd6;
  localparam logic [6:0] FLAG_CHUNK_W = 7'd10;
  localparam logic [6:0] SUM_CHUNK_W  = 7'd16;

  typedef struct packed {
    logic                               is_time;
    logic [63:0]                        delta;
    logic [FlagWordW-1:0]               flags;
    logic [NumGroups-1:0][SumW-1:0]     sums;
  } entry_t;

  function automatic logic [GroupIdxW-1:0] group_of(input logic [3:0] idx);
    logic [GroupIdxW-1:0] g;
    unique case (idx) inside
      [4'd0:4'd3]:   g = 3'd0;
      [4'd4:4'd6]:   g = 3'd1;
      [4'd7:4'd9]:   g = 3'd2;
      [4'd10:4'd12]: g = 3'd3;
      default:       g = 3'd4;
    endcase
    return g;
  endfunction

  // highest set bit plus one; zero gives one
  function automatic logic [6:0] bit_len(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd1;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        n = 7'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

[rtl/tde_front.sv]
// Front end: accepts record words, tracks the timestamp and sensor groups, builds queue entries.
module tde_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [59:0]     word_i,
  output logic            enq_valid_o,
  output tde_pkg::entry_t enq_data_o
);

  logic [4:0]  wc_q, wc_d;
  logic [59:0] prev_q, prev_d;
  logic        have_q, have_d;
  logic [tde_pkg::SumW-1:0] sum_q [tde_pkg::NumGroups];
  logic [tde_pkg::SumW-1:0] sum_d [tde_pkg::NumGroups];
  tde_pkg::flag_t flag_q [tde_pkg::NumGroups];
  tde_pkg::flag_t flag_d [tde_pkg::NumGroups];
  logic [tde_pkg::NumGroups-1:0] closed_q, closed_d;

  logic [3:0]  idx;
  logic [tde_pkg::GroupIdxW-1:0] grp;
  logic [1:0]  typ;
  logic [13:0] val;
  logic        is_ts;
  logic        last_word;
  logic [63:0] delta;

  assign idx       = wc_q[3:0] - 4'd1;
  assign grp       = tde_pkg::group_of(idx);
  assign typ       = word_i[15:14];
  assign val       = word_i[13:0];
  assign is_ts     = (wc_q == 5'd0) || (wc_q > 5'd16);
  assign last_word = (wc_q == 5'd16);
  assign delta     = have_q ? ({4'b0, word_i} - {4'b0, prev_q}) : {4'b0, word_i};

  always_comb begin
    wc_d     = wc_q;
    prev_d   = prev_q;
    have_d   = have_q;
    sum_d    = sum_q;
    flag_d   = flag_q;
    closed_d = closed_q;
    if (accept_i) begin
      if (is_ts) begin
        prev_d = word_i;
        have_d = 1'b1;
        wc_d   = 5'd1;
        for (int g = 0; g < tde_pkg::NumGroups; g++) begin
          sum_d[g]    = '0;
          flag_d[g]   = tde_pkg::FLAG_NONE;
          closed_d[g] = 1'b0;
        end
      end else begin
        if (!closed_q[grp]) begin
          case (typ)
            tde_pkg::TYPE_NODATA: begin
              flag_d[grp]   = tde_pkg::FLAG_NODATA;
              closed_d[grp] = 1'b1;
            end
            tde_pkg::TYPE_SAT: begin
              if (flag_q[grp] == tde_pkg::FLAG_NONE) begin
                flag_d[grp] = tde_pkg::FLAG_SAT;
              end
            end
            default: begin
              if (flag_q[grp] == tde_pkg::FLAG_NONE || flag_q[grp] == tde_pkg::FLAG_SAT) begin
                flag_d[grp] = {1'b0, typ};
              end
              sum_d[grp] = sum_q[grp] + {2'b00, val};
            end
          endcase
        end
        wc_d = last_word ? 5'd0 : wc_q + 5'd1;
      end
    end
  end

  always_comb begin
    enq_data_o.is_time = is_ts;
    enq_data_o.delta   = delta;
    for (int g = 0; g < tde_pkg::NumGroups; g++) begin
      enq_data_o.flags[2*(tde_pkg::NumGroups-1-g) +: 2] =
        flag_d[g][2] ? 2'b00 : flag_d[g][1:0];
      enq_data_o.sums[g] =
        (flag_d[g] == tde_pkg::FLAG_NODATA || flag_d[g] == tde_pkg::FLAG_SAT) ? '0 : sum_d[g];
    end
  end

  assign enq_valid_o = accept_i & (is_ts | last_word);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q     <= '0;
      prev_q   <= '0;
      have_q   <= 1'b0;
      closed_q <= '0;
      for (int g = 0; g < tde_pkg::NumGroups; g++) begin
        sum_q[g]  <= '0;
        flag_q[g] <= tde_pkg::FLAG_NONE;
      end
    end else begin
      wc_q     <= wc_d;
      prev_q   <= prev_d;
      have_q   <= have_d;
      closed_q <= closed_d;
      sum_q    <= sum_d;
      flag_q   <= flag_d;
    end
  end

endmodule

[rtl/tde_fifo.sv]
// Two-entry queue between the front end and the chunk emitter.
module tde_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  tde_pkg::entry_t wr_data_i,
  output logic            full_o,
  input  logic            rd_en_i,
  output tde_pkg::entry_t rd_data_o,
  output logic            rd_valid_o
);

  localparam int Depth = 2;

  tde_pkg::entry_t mem_q [Depth];
  logic            wr_ptr_q;
  logic            rd_ptr_q;
  logic [1:0]      count_q;

  assign full_o     = (count_q == 2'(Depth));
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd_en_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, wr_en_i} - {1'b0, rd_en_i};
    end
  end

endmodule

[rtl/tde_back.sv]
// Back end: takes queue entries and emits their chunks one per transaction.
module tde_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            deq_valid_i,
  input  tde_pkg::entry_t deq_data_i,
  output logic            deq_en_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [63:0]     chunk_bits_o,
  output logic [6:0]      chunk_len_o,
  output logic            chunk_last_o
);

  logic        busy_q;
  logic        step_q;
  logic        is_time_q;
  logic [63:0] delta_q;
  logic [6:0]  len_q;
  logic [tde_pkg::FlagWordW-1:0] flags_q;
  logic [tde_pkg::NumGroups-1:0][tde_pkg::SumW-1:0] sums_q;
  logic [tde_pkg::NumGroups-1:0] nz_q;

  logic [tde_pkg::NumGroups-1:0] sel;
  logic [tde_pkg::NumGroups-1:0] nz_rest;
  logic [tde_pkg::SumW-1:0]      sel_sum;
  logic [tde_pkg::NumGroups-1:0] nz_load;
  logic advance, finish, load;

  assign sel     = nz_q & (~nz_q + {{(tde_pkg::NumGroups-1){1'b0}}, 1'b1});
  assign nz_rest = nz_q & ~sel;

  always_comb begin
    sel_sum = '0;
    for (int g = 0; g < tde_pkg::NumGroups; g++) begin
      sel_sum = sel_sum | (sums_q[g] & {tde_pkg::SumW{sel[g]}});
      nz_load[g] = (deq_data_i.sums[g] != '0);
    end
  end

  always_comb begin
    if (is_time_q) begin
      if (!step_q) begin
        chunk_bits_o = {58'b0, len_q[5:0]};
        chunk_len_o  = tde_pkg::LEN_CHUNK_W;
        chunk_last_o = 1'b0;
      end else begin
        chunk_bits_o = delta_q;
        chunk_len_o  = len_q;
        chunk_last_o = 1'b1;
      end
    end else begin
      if (!step_q) begin
        chunk_bits_o = {54'b0, flags_q};
        chunk_len_o  = tde_pkg::FLAG_CHUNK_W;
        chunk_last_o = (nz_q == '0);
      end else begin
        chunk_bits_o = {48'b0, sel_sum};
        chunk_len_o  = tde_pkg::SUM_CHUNK_W;
        chunk_last_o = (nz_rest == '0);
      end
    end
  end

  assign empty_o  = ~busy_q;
  assign advance  = busy_q & pop_i;
  assign finish   = advance & chunk_last_o;
  assign load     = deq_valid_i & (~busy_q | finish);
  assign deq_en_o = load;

  always_ff @(posedge clk_i) begin
    if (load) begin
      is_time_q <= deq_data_i.is_time;
      delta_q   <= deq_data_i.delta;
      len_q     <= tde_pkg::bit_len(deq_data_i.delta);
      flags_q   <= deq_data_i.flags;
      sums_q    <= deq_data_i.sums;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 1'b0;
      nz_q   <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      step_q <= 1'b0;
      nz_q   <= nz_load;
    end else if (finish) begin
      busy_q <= 1'b0;
    end else if (advance) begin
      if (!step_q) begin
        step_q <= 1'b1;
      end else begin
        nz_q <= nz_rest;
      end
    end
  end

endmodule

[rtl/telemetry_record_delta_encoder.sv]
// Top level of the telemetry record delta encoder.
// A timestamp or 16th sensor word is queued and then loaded into the emitter for its chunks.
// Throughput: one word per cycle in unless full; one chunk per cycle on pop, by the one emitter.
// A two-entry queue lets the word front end run while chunks wait on the output.
// Reset (async, active low) clears timestamp history, word count, groups and the queue at once.
module telemetry_record_delta_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [59:0] word_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] chunk_bits_o,
  output logic [6:0]  chunk_len_o,
  output logic        chunk_last_o
);

  logic            accept;
  logic            enq_valid;
  tde_pkg::entry_t enq_data;
  logic            deq_valid;
  logic            deq_en;
  tde_pkg::entry_t deq_data;

  assign accept = push & ~full;

  tde_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .word_i      (word_i),
    .enq_valid_o (enq_valid),
    .enq_data_o  (enq_data)
  );

  tde_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (enq_valid),
    .wr_data_i  (enq_data),
    .full_o     (full),
    .rd_en_i    (deq_en),
    .rd_data_o  (deq_data),
    .rd_valid_o (deq_valid)
  );

  tde_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .deq_valid_i  (deq_valid),
    .deq_data_i   (deq_data),
    .deq_en_o     (deq_en),
    .pop_i        (pop),
    .empty_o      (empty),
    .chunk_bits_o (chunk_bits_o),
    .chunk_len_o  (chunk_len_o),
    .chunk_last_o (chunk_last_o)
  );

endmodule

[rtl/tde_checker.sv]
// Port-level checker for the telemetry record delta encoder, bound to the top level.
module tde_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [63:0] chunk_bits_o,
  input logic [6:0]  chunk_len_o,
  input logic        chunk_last_o
);

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (chunk_len_o != 7'd0) && (chunk_len_o <= 7'd64))
    else $error("chunk length out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(chunk_bits_o) && $stable(chunk_len_o)
                          && $stable(chunk_last_o)))
    else $error("stalled transaction changed");

  // bits above the chunk length stay clear
  a_bits_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && chunk_len_o < 7'd64) |-> ((chunk_bits_o >> chunk_len_o) == 64'd0))
    else $error("chunk bits wider than length");

  a_sum_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && chunk_len_o == 7'd16)
      |-> (chunk_bits_o != 64'd0) && (chunk_bits_o[63:16] == 48'd0))
    else $error("bad group sum chunk");

endmodule

bind telemetry_record_delta_encoder tde_checker u_tde_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .chunk_bits_o (chunk_bits_o),
  .chunk_len_o  (chunk_len_o),
  .chunk_last_o (chunk_last_o)
);
